// ===== rtl/ring_array_engine_assert.svh =====
// Assertion macros shared by the ring array engine RTL.
// Needs clk and rst in the scope of each use.
`ifndef RING_ARRAY_ENGINE_ASSERT_SVH
`define RING_ARRAY_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RAE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ring_array_engine: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RAE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ring_array_engine: next-cycle check failed");

`endif

// ===== rtl/rae_pkg.sv =====
// Types and constants for the ring array engine.
// Used by rae_store, rae_ctrl and ring_array_engine; no dependencies.
package rae_pkg;

  localparam int DEPTH  = 16;
  localparam int WIDTH  = 32;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = AW + 1;
  localparam int POS_W  = 4;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 5;
  localparam int CMPW   = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_POP     = 2'd1,
    REQ_REPLACE = 2'd2,
    REQ_INSERT  = 2'd3
  } rae_req_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } rae_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_POP_WAIT,
    ST_FINISH
  } rae_state_t;

  typedef struct packed {
    logic             we;
    logic [AW-1:0]    waddr;
    logic [WIDTH-1:0] wdata;
    logic             re;
    logic [AW-1:0]    raddr;
  } rae_mem_req_t;

  typedef struct packed {
    rae_stat_t        status;
    logic [VAL_W-1:0] popped;
    logic [CNT_W-1:0] count;
  } rae_result_t;

endpackage

// ===== rtl/ring_array_engine.sv =====
// Ring array engine: 16-entry ring deque with push, pop, replace and insert.
// A request is registered, decoded, then finished for push, replace and rejected
// requests; a successful pop adds a pop-wait state, an insert a shift-read and
// shift-write pair per entry moved plus a final write. One transaction at a time:
// the next is accepted once the result is taken, which output stalls can delay.
// Synchronous active-high reset clears front and count; store is not cleared.
module ring_array_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [3:0]  position,
  input  logic [31:0] entry_value,
  input  logic        zero_fill,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] popped_value,
  output logic [4:0]  live_count
);

  rae_pkg::rae_mem_req_t      mem_req;
  logic [rae_pkg::WIDTH-1:0]  rd_data;
  logic                       res_valid;
  logic                       res_take;
  rae_pkg::rae_result_t       res;
  rae_pkg::rae_result_t       out_res;

  rae_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  rae_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .position    (position),
    .entry_value (entry_value),
    .zero_fill   (zero_fill),
    .mem_req     (mem_req),
    .rd_data     (rd_data),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res)
  );

  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_res <= res;
    end
  end

  assign status       = out_res.status;
  assign popped_value = out_res.popped;
  assign live_count   = out_res.count;

endmodule

// ===== rtl/rae_store.sv =====
// Entry storage: one write port, one read port with registered read data.
// Depends on rae_pkg.
module rae_store (
  input  logic                        clk,
  input  rae_pkg::rae_mem_req_t       req,
  output logic [rae_pkg::WIDTH-1:0]   rd_data
);

  logic [rae_pkg::WIDTH-1:0] mem [rae_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/rae_ctrl.sv =====
// Request sequencer: decodes a transaction, drives the store through one
// shared slot-address adder, and walks inserts one entry at a time.
// Depends on rae_pkg and ring_array_engine_assert.svh.
`include "ring_array_engine_assert.svh"

module rae_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  req_type,
  input  logic [rae_pkg::POS_W-1:0]   position,
  input  logic [rae_pkg::VAL_W-1:0]   entry_value,
  input  logic                        zero_fill,
  output rae_pkg::rae_mem_req_t       mem_req,
  input  logic [rae_pkg::WIDTH-1:0]   rd_data,
  output logic                        res_valid,
  input  logic                        res_take,
  output rae_pkg::rae_result_t        res
);

  rae_pkg::rae_state_t            state, state_next;
  rae_pkg::rae_req_t              req_q;
  logic [rae_pkg::POS_W-1:0]      pos_q;
  logic [rae_pkg::WIDTH-1:0]      val_q;
  logic                           zf_q;
  logic [rae_pkg::AW-1:0]         front, front_next;
  logic [rae_pkg::CW-1:0]         count, count_next;
  logic [rae_pkg::CW-1:0]         j, j_next;
  rae_pkg::rae_stat_t             stat_q, stat_next;
  logic [rae_pkg::WIDTH-1:0]      popped_q, popped_next;

  logic [rae_pkg::CW-1:0]         idx;
  logic [rae_pkg::CW-1:0]         sum;
  logic [rae_pkg::AW-1:0]         slot;
  logic [rae_pkg::CMPW-1:0]       pos_x, count_x, j_x;
  logic                           full, out_of_range, shift_done;

  assign pos_x        = rae_pkg::CMPW'(pos_q);
  assign count_x      = rae_pkg::CMPW'(count);
  assign j_x          = rae_pkg::CMPW'(j);
  assign full         = (count == rae_pkg::CW'(rae_pkg::DEPTH));
  assign out_of_range = (pos_x >= count_x);
  assign shift_done   = (j_x == pos_x);

  // Shared slot adder: (front + idx) mod DEPTH, idx never above DEPTH.
  always_comb begin
    idx = '0;
    case (state)
      rae_pkg::ST_DECODE: begin
        case (req_q)
          rae_pkg::REQ_PUSH:    idx = count;
          rae_pkg::REQ_REPLACE: idx = rae_pkg::CW'(pos_q);
          default:              idx = '0;
        endcase
      end
      rae_pkg::ST_SHIFT_RD: idx = shift_done ? j : j - rae_pkg::CW'(1);
      rae_pkg::ST_SHIFT_WR: idx = j;
      rae_pkg::ST_POP_WAIT: idx = rae_pkg::CW'(1);
      default:              idx = '0;
    endcase
    sum  = rae_pkg::CW'(front) + idx;
    slot = (sum >= rae_pkg::CW'(rae_pkg::DEPTH)) ?
           rae_pkg::AW'(sum - rae_pkg::CW'(rae_pkg::DEPTH)) : rae_pkg::AW'(sum);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rae_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = rae_pkg::ST_DECODE;
        end
      end
      rae_pkg::ST_DECODE: begin
        case (req_q)
          rae_pkg::REQ_POP:
            state_next = (count == '0) ? rae_pkg::ST_FINISH : rae_pkg::ST_POP_WAIT;
          rae_pkg::REQ_INSERT:
            state_next = (out_of_range || full) ? rae_pkg::ST_FINISH : rae_pkg::ST_SHIFT_RD;
          default:
            state_next = rae_pkg::ST_FINISH;
        endcase
      end
      rae_pkg::ST_SHIFT_RD: state_next = shift_done ? rae_pkg::ST_FINISH : rae_pkg::ST_SHIFT_WR;
      rae_pkg::ST_SHIFT_WR: state_next = rae_pkg::ST_SHIFT_RD;
      rae_pkg::ST_POP_WAIT: state_next = rae_pkg::ST_FINISH;
      rae_pkg::ST_FINISH: begin
        if (res_take) begin
          state_next = rae_pkg::ST_IDLE;
        end
      end
      default: state_next = rae_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    mem_req     = '0;
    front_next  = front;
    count_next  = count;
    j_next      = j;
    stat_next   = stat_q;
    popped_next = popped_q;
    case (state)
      rae_pkg::ST_DECODE: begin
        stat_next   = rae_pkg::STAT_DONE;
        popped_next = '0;
        case (req_q)
          rae_pkg::REQ_PUSH: begin
            if (full) begin
              stat_next = rae_pkg::STAT_FULL;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = slot;
              mem_req.wdata = zf_q ? '0 : val_q;
              count_next    = count + rae_pkg::CW'(1);
            end
          end
          rae_pkg::REQ_POP: begin
            if (count == '0) begin
              stat_next = rae_pkg::STAT_EMPTY;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = front;
            end
          end
          rae_pkg::REQ_REPLACE: begin
            if (out_of_range) begin
              stat_next = rae_pkg::STAT_RANGE;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = slot;
              mem_req.wdata = val_q;
            end
          end
          default: begin
            if (out_of_range) begin
              stat_next = rae_pkg::STAT_RANGE;
            end else if (full) begin
              stat_next = rae_pkg::STAT_FULL;
            end else begin
              j_next = count;
            end
          end
        endcase
      end
      rae_pkg::ST_SHIFT_RD: begin
        if (shift_done) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = slot;
          mem_req.wdata = val_q;
          count_next    = count + rae_pkg::CW'(1);
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = slot;
        end
      end
      rae_pkg::ST_SHIFT_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = slot;
        mem_req.wdata = rd_data;
        j_next        = j - rae_pkg::CW'(1);
      end
      rae_pkg::ST_POP_WAIT: begin
        popped_next = rd_data;
        front_next  = (count == rae_pkg::CW'(1)) ? '0 : slot;
        count_next  = count - rae_pkg::CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rae_pkg::ST_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rae_pkg::ST_IDLE && in_valid) begin
      req_q <= rae_pkg::rae_req_t'(req_type);
      pos_q <= position;
      val_q <= rae_pkg::WIDTH'(entry_value);
      zf_q  <= zero_fill;
    end
    j        <= j_next;
    stat_q   <= stat_next;
    popped_q <= popped_next;
  end

  assign in_stall   = (state != rae_pkg::ST_IDLE);
  assign res_valid  = (state == rae_pkg::ST_FINISH);
  assign res.status = stat_q;
  assign res.popped = rae_pkg::VAL_W'(popped_q);
  assign res.count  = rae_pkg::CNT_W'(count);

  `RAE_ASSERT_NOW(a_count_bound, 1'b1, count <= rae_pkg::CW'(rae_pkg::DEPTH))
  `RAE_ASSERT_NOW(a_empty_front, count == '0, front == '0)
  `RAE_ASSERT_NOW(a_shift_range, state == rae_pkg::ST_SHIFT_RD, j_x >= pos_x && j <= count)
  `RAE_ASSERT_NEXT(a_pop_dec, state == rae_pkg::ST_POP_WAIT, count == $past(count) - rae_pkg::CW'(1))

endmodule
